[rtl/thg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Touch gesture hold aggregator package
// Shared types and codes for the event input, the derived results and the
// gesture kinds and phases.
// ----------------------------------------------------------------------------
package thg_pkg;

    localparam int POS_W   = 16;
    localparam int COUNT_W = 4;
    localparam int TIME_W  = 31;
    localparam int THR_W   = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd500;

    // Primitive gesture kinds.
    localparam logic [2:0] K_TAP      = 3'd0;
    localparam logic [2:0] K_LONG     = 3'd1;
    localparam logic [2:0] K_DOUBLE   = 3'd2;
    localparam logic [2:0] K_TRIPLE   = 3'd3;
    localparam logic [2:0] K_MOMENTUM = 3'd4;
    localparam logic [2:0] K_LINE     = 3'd5;
    localparam logic [2:0] K_FLICK    = 3'd6;

    // Primitive gesture phases.
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_MOVE  = 3'd1;

    // Derived gesture kinds and phases.
    localparam logic       DK_HOVER  = 1'b0;
    localparam logic       DK_HOLD   = 1'b1;
    localparam logic [1:0] DPH_START = 2'd0;
    localparam logic [1:0] DPH_MOVE  = 2'd1;
    localparam logic [1:0] DPH_END   = 2'd2;

    typedef struct packed {
        logic [2:0]                kind;
        logic [2:0]                phase;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic [COUNT_W-1:0]        finger_count;
        logic [TIME_W-1:0]         time_stamp;
    } event_t;

    typedef struct packed {
        logic                      kind;
        logic [1:0]                phase;
        logic signed [POS_W-1:0]   out_x;
        logic signed [POS_W-1:0]   out_y;
        logic [COUNT_W-1:0]        out_count;
        logic [TIME_W-1:0]         out_time;
        logic                      last;
    } result_t;

    function automatic logic [1:0] derive_phase(input logic was_on, input logic now_on);
        logic [1:0] ph;
        if (!was_on && now_on) begin
            ph = DPH_START;
        end else if (was_on && !now_on) begin
            ph = DPH_END;
        end else begin
            ph = DPH_MOVE;
        end
        return ph;
    endfunction

endpackage
`default_nettype wire

[rtl/thg_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Gesture timekeeping core
// Holds the start times of the primitive and derived gestures, updates them
// for one event and forms the zero, one or two derived results it causes.
// ----------------------------------------------------------------------------
module thg_core
    import thg_pkg::*;
#(
    parameter int TIME_BITS = 31
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire event_t           item,
    input  wire logic [THR_W-1:0] hold_threshold,
    output result_t               res0,
    output result_t               res1,
    output logic [1:0]            res_cnt
);

    logic [TIME_BITS-1:0] lt_reg, dt_reg, tt_reg, mt_reg, hv_reg, hd_reg;
    logic [TIME_BITS-1:0] lt_next, dt_next, tt_next, mt_next, hv_next, hd_next;
    logic [TIME_BITS-1:0] ts;
    logic [TIME_BITS-1:0] thr;
    logic                 kind_ok;
    logic                 start_move;
    logic                 hover_emit, hold_emit;
    result_t              hover_res, hold_res;

    assign ts         = item.time_stamp[TIME_BITS-1:0];
    assign thr        = TIME_BITS'(hold_threshold);
    assign kind_ok    = (item.kind <= K_FLICK);
    assign start_move = (item.phase == PH_START) || (item.phase == PH_MOVE);

    always_comb begin
        lt_next = lt_reg;
        dt_next = dt_reg;
        tt_next = tt_reg;
        mt_next = mt_reg;
        hv_next = hv_reg;
        hd_next = hd_reg;
        if (start_move) begin
            case (item.kind)
                K_MOMENTUM: mt_next = ts;
                K_LONG:     if (lt_reg == '0) lt_next = ts;
                K_DOUBLE:   if (dt_reg == '0) dt_next = ts;
                K_TRIPLE:   tt_next = ts;
                default:    ;
            endcase
        end else begin
            case (item.kind)
                K_MOMENTUM: mt_next = '0;
                K_LONG:     lt_next = '0;
                K_DOUBLE:   dt_next = '0;
                K_TRIPLE:   tt_next = '0;
                default:    ;
            endcase
            if (lt_next == '0 && dt_next == '0 && tt_next == '0 && mt_next == '0) begin
                hv_next = '0;
                hd_next = '0;
            end
        end
        if (lt_next != '0 && hv_next == '0 && ts > lt_next && (ts - lt_next) > thr) begin
            hv_next = ts;
        end
        if (dt_next != '0 && hd_next == '0 && ts > dt_next && (ts - dt_next) > thr) begin
            hd_next = ts;
        end
    end

    assign hover_emit = kind_ok && ((hv_reg != '0) || (hv_next != '0));
    assign hold_emit  = kind_ok && ((hd_reg != '0) || (hd_next != '0));

    always_comb begin
        hover_res.kind      = DK_HOVER;
        hover_res.phase     = derive_phase(hv_reg != '0, hv_next != '0);
        hover_res.out_x     = item.pos_x;
        hover_res.out_y     = item.pos_y;
        hover_res.out_count = item.finger_count;
        hover_res.out_time  = TIME_W'(ts);
        hover_res.last      = !hold_emit;

        hold_res.kind      = DK_HOLD;
        hold_res.phase     = derive_phase(hd_reg != '0, hd_next != '0);
        hold_res.out_x     = item.pos_x;
        hold_res.out_y     = item.pos_y;
        hold_res.out_count = item.finger_count;
        hold_res.out_time  = TIME_W'(ts);
        hold_res.last      = 1'b1;

        res0    = hover_emit ? hover_res : hold_res;
        res1    = hold_res;
        res_cnt = 2'(hover_emit) + 2'(hold_emit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lt_reg <= '0;
            dt_reg <= '0;
            tt_reg <= '0;
            mt_reg <= '0;
            hv_reg <= '0;
            hd_reg <= '0;
        end else if (fire && kind_ok) begin
            lt_reg <= lt_next;
            dt_reg <= dt_next;
            tt_reg <= tt_next;
            mt_reg <= mt_next;
            hv_reg <= hv_next;
            hd_reg <= hd_next;
        end
    end

endmodule
`default_nettype wire

[rtl/thg_res_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Result buffer
// Two-slot result register. Loads all results of one event at once and
// presents them one per transfer, head slot first.
// ----------------------------------------------------------------------------
module thg_res_buf
    import thg_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t res0,
    input  wire result_t res1,
    input  wire logic [1:0] res_cnt,
    input  wire logic    pop,
    output result_t      head,
    output logic [1:0]   cnt
);

    result_t    slot0_reg, slot1_reg;
    logic [1:0] cnt_reg;

    assign head = slot0_reg;
    assign cnt  = cnt_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= res_cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

[rtl/touch_gesture_hold_aggregator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Touch gesture hold aggregator
// Tracks long, double and triple tap and momentum start times from primitive
// touch events and derives hover and double-tap-and-hold gestures.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_tvalid/s_tready    event: kind, phase, x, y, count, time
//   m_       out        m_tvalid/m_tready    derived result, m_tlast on final one
//   cfg_     in         cfg_valid/cfg_ready  hold_threshold
//
// An event is registered, then processed combinationally into the result buffer.
// Events with one or no result sustain one transfer per cycle unless the
// output stalls; two-result events are paced by the single result port.
// Reset clears all gesture times and sets the threshold to 500.
// A stalled output holds the buffer; one event can wait in the input register.
// ----------------------------------------------------------------------------
module touch_gesture_hold_aggregator
    import thg_pkg::*;
#(
    parameter int TIME_BITS = 31
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pos_x[15:0], pos_y[31:16], finger_count[35:32], time_stamp[66:36], zero
    input  wire logic [71:0] s_tdata,
    // gesture_kind[2:0], gesture_phase[5:3]
    input  wire logic [5:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_x[15:0], out_y[31:16], out_count[35:32], out_time[66:36], zero
    output logic [71:0]      m_tdata,
    // derived_kind[0], derived_phase[2:1]
    output logic [2:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    event_t           item_reg;
    logic             item_valid_reg;
    logic [THR_W-1:0] thr_reg;
    logic             fire;
    logic             pop;
    logic [1:0]       buf_cnt;
    logic [1:0]       res_cnt;
    result_t          res0, res1, head;

    assign cfg_ready = 1'b1;
    assign pop       = m_tvalid && m_tready;
    assign fire      = item_valid_reg && ((buf_cnt == 2'd0) || (buf_cnt == 2'd1 && pop));
    assign s_tready  = !item_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.kind         <= s_tuser[2:0];
            item_reg.phase        <= s_tuser[5:3];
            item_reg.pos_x        <= s_tdata[15:0];
            item_reg.pos_y        <= s_tdata[31:16];
            item_reg.finger_count <= s_tdata[35:32];
            item_reg.time_stamp   <= s_tdata[66:36];
        end
    end

    thg_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (fire),
        .item           (item_reg),
        .hold_threshold (thr_reg),
        .res0           (res0),
        .res1           (res1),
        .res_cnt        (res_cnt)
    );

    thg_res_buf u_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt),
        .pop     (pop),
        .head    (head),
        .cnt     (buf_cnt)
    );

    assign m_tvalid = (buf_cnt != 2'd0);
    assign m_tdata  = {5'd0, head.out_time, head.out_count, head.out_y, head.out_x};
    assign m_tuser  = {head.phase, head.kind};
    assign m_tlast  = head.last;

    a_buf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_cnt != 2'd3)
        else $error("result buffer holds more than two results");

    a_two_first: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_cnt == 2'd2 |=> m_tvalid && !m_tlast && m_tuser[0] == DK_HOVER)
        else $error("first of two results is not a non-final hover result");

    a_none_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_cnt == 2'd0 && buf_cnt == 2'd0 |=> !m_tvalid)
        else $error("result shown for an event that causes none");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_cnt == 2'd1 |=> m_tvalid && m_tlast)
        else $error("single result of an event is not marked last");

endmodule
`default_nettype wire
